// ===== rtl/efsm_pkg.sv =====
// Shared types and constants for the editable state-machine block.
// Command and status codes, sequencer states, reset contents of the edge tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package efsm_pkg;

   // command codes (req op field)
   localparam logic [2:0] OP_STEP     = 3'd0;
   localparam logic [2:0] OP_EDIT     = 3'd1;
   localparam logic [2:0] OP_COLLECT  = 3'd2;
   localparam logic [2:0] OP_DEL_UNR  = 3'd3;
   localparam logic [2:0] OP_DEL_ONE  = 3'd4;

   // status codes (rsp status field)
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_IS_CUR   = 3'd1;
   localparam logic [2:0] ST_REF      = 3'd2;
   localparam logic [2:0] ST_NONE     = 3'd3;
   localparam logic [2:0] ST_REJECT   = 3'd4;

   // item field widths
   localparam int OP_W    = 3;
   localparam int TGT_W   = 3;
   localparam int PS_W    = 3;
   localparam int MASK_W  = 8;
   localparam int COUNT_W = 4;
   localparam int STAT_W  = 3;

   // reset contents of the first eight table entries
   localparam logic [2:0] ZERO_TABLE [8] = '{3'd3, 3'd1, 3'd1, 3'd0, 3'd2, 3'd5, 3'd4, 3'd3};
   localparam logic [2:0] ONE_TABLE  [8] = '{3'd5, 3'd2, 3'd6, 3'd4, 3'd2, 3'd0, 3'd1, 3'd0};

   typedef enum logic [2:0] {
      S_INIT,   // table fill after reset
      S_IDLE,   // waiting for a command
      S_STEP,   // table read of the current state returns
      S_SCAN,   // sweep over all entries (closure or reference check)
      S_DONE    // result waits for the output register
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/efsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the edge tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module efsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/editable_fsm_with_reachability_gc.sv =====
// From accept to rsp_tvalid: a step passes S_STEP and S_DONE, edit and refused commands
// go straight to S_DONE, delete-one makes one scan pass over the table, and collect /
// delete-unreachable make 1 to NUM_STATES closure passes, until a pass adds nothing.
// One command at a time; the table sweep through the shared RAM read address sets the rate.
// Synchronous active-high reset, then a fill of the edge tables with req_tready low.
`timescale 1ns / 1ps
`default_nettype none

module editable_fsm_with_reachability_gc
   import efsm_pkg::*;
#(
   parameter int NUM_STATES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // op[2:0], edge_bit[3], target_state[6:4], zero[7]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata    // present_state[2:0], unreachable_mask[10:3],
                                         // unreachable_count[14:11], status[17:15], zero
);

   localparam int IDX_W = $clog2(NUM_STATES);
   localparam int CNT_W = IDX_W + 1;
   // compare width wide enough for a 3-bit target, a state index and NUM_STATES
   localparam int CW    = ((IDX_W > TGT_W) ? IDX_W : TGT_W) + 1;
   localparam int MW    = (NUM_STATES > MASK_W) ? NUM_STATES : MASK_W;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_STATES);
   localparam logic [CNT_W-1:0] FILL_END = CNT_W'(NUM_STATES - 1);
   localparam logic [CW-1:0]    N_CW     = CW'(NUM_STATES);

   // ---------------------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------------------
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;           // fill / sweep address counter
   logic [IDX_W-1:0]        cur_ff, cur_in;           // current state
   logic [NUM_STATES-1:0]   valid_ff, valid_in;       // per-state valid bits
   logic [OP_W-1:0]         op_ff, op_in;
   logic                    bit_ff, bit_in;
   logic [IDX_W-1:0]        tgt_ff, tgt_in;
   logic [NUM_STATES-1:0]   reach_ff, reach_in;       // reachable set under construction
   logic                    changed_ff, changed_in;   // this pass grew the set
   logic                    ref_ff, ref_in;           // delete target is referenced
   logic [COUNT_W-1:0]      ucnt_ff, ucnt_in;         // unreachable count, this pass
   logic                    pvld_ff, pvld_in;         // RAM data in this cycle is live
   logic [IDX_W-1:0]        pidx_ff, pidx_in;         // entry whose data is returning
   logic [STAT_W-1:0]       pstat_ff, pstat_in;
   logic [MASK_W-1:0]       pmask_ff, pmask_in;
   logic [COUNT_W-1:0]      pcount_ff, pcount_in;
   logic                    rvld_ff, rvld_in;
   logic [PS_W-1:0]         rstate_ff, rstate_in;
   logic [MASK_W-1:0]       rmask_ff, rmask_in;
   logic [COUNT_W-1:0]      rcount_ff, rcount_in;
   logic [STAT_W-1:0]       rstat_ff, rstat_in;

   // ---------------------------------------------------------------------------------
   // edge tables: one RAM per input bit, both read at the same address
   // ---------------------------------------------------------------------------------
   logic               wr0_en, wr1_en;
   logic [IDX_W-1:0]   wr_addr, wr0_data, wr1_data, rd_addr, d0, d1;

   efsm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_STATES)) u_ram0 (
      .clock   (clock),
      .wr_en   (wr0_en),
      .wr_addr (wr_addr),
      .wr_data (wr0_data),
      .rd_addr (rd_addr),
      .rd_data (d0)
   );

   efsm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_STATES)) u_ram1 (
      .clock   (clock),
      .wr_en   (wr1_en),
      .wr_addr (wr_addr),
      .wr_data (wr1_data),
      .rd_addr (rd_addr),
      .rd_data (d1)
   );

   // ---------------------------------------------------------------------------------
   // command decode
   // ---------------------------------------------------------------------------------
   logic [OP_W-1:0]  req_op;
   logic             req_bit;
   logic [TGT_W-1:0] req_tgt;
   logic [CW-1:0]    tgt_cw, cur_cw;
   logic [IDX_W-1:0] tgt_idx;
   logic             tgt_live, tgt_is_cur, accept;

   assign req_op     = req_tdata[2:0];
   assign req_bit    = req_tdata[3];
   assign req_tgt    = req_tdata[6:4];
   assign tgt_cw     = CW'(req_tgt);
   assign cur_cw     = CW'(cur_ff);
   assign tgt_idx    = tgt_cw[IDX_W-1:0];
   // out-of-range targets count as deleted
   assign tgt_live   = (tgt_cw < N_CW) && valid_ff[tgt_idx];
   assign tgt_is_cur = (tgt_cw == cur_cw);
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // ---------------------------------------------------------------------------------
   // reset contents for the fill pass: table value mod NUM_STATES, self loop at and above 8
   // ---------------------------------------------------------------------------------
   logic [CW-1:0] fill_idx, fill0, fill1;

   always_comb begin
      fill_idx = CW'(cnt_ff);
      fill0    = (fill_idx < CW'(8)) ? CW'(ZERO_TABLE[fill_idx[2:0]]) : fill_idx;
      fill1    = (fill_idx < CW'(8)) ? CW'(ONE_TABLE[fill_idx[2:0]]) : fill_idx;
      // values stay below 8 and NUM_STATES is at least 2: three subtractions suffice
      for (int k = 0; k < 3; k++) begin
         if (fill0 >= N_CW) fill0 = fill0 - N_CW;
         if (fill1 >= N_CW) fill1 = fill1 - N_CW;
      end
   end

   // ---------------------------------------------------------------------------------
   // sweep evaluation of the entry whose RAM data is returning
   // ---------------------------------------------------------------------------------
   logic                  live, reach_bit, changed_now, ref_now, unr_now, pass_end;
   logic                  reach_mode, load_rsp;
   logic [NUM_STATES-1:0] reach_add, reach_next, unr_set;
   logic [MW-1:0]         unr_wide;
   logic [COUNT_W-1:0]    ucnt_next;

   assign live        = pvld_ff && valid_ff[pidx_ff];
   assign reach_bit   = reach_ff[pidx_ff];
   assign reach_add   = (live && reach_bit)
                        ? ((NUM_STATES'(1) << d0) | (NUM_STATES'(1) << d1)) : '0;
   assign reach_next  = reach_ff | reach_add;
   assign changed_now = (reach_next != reach_ff);
   assign ref_now     = live && ((d0 == tgt_ff) || (d1 == tgt_ff));
   assign unr_now     = live && !reach_bit;
   // count is valid only for a pass that added nothing, when reach_ff was final
   assign ucnt_next   = (unr_now && (ucnt_ff != '1)) ? ucnt_ff + COUNT_W'(1) : ucnt_ff;
   assign pass_end    = (cnt_ff == LAST_CNT);
   assign reach_mode  = (op_ff != OP_DEL_ONE);
   assign unr_set     = valid_ff & ~reach_ff;
   assign unr_wide    = MW'(unr_set);
   assign load_rsp    = (state_ff == S_DONE) && (!rvld_ff || rsp_tready);

   // ---------------------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            if (cnt_ff == FILL_END) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               case (req_op) inside
                  OP_STEP:                 state_in = S_STEP;
                  OP_COLLECT, OP_DEL_UNR:  state_in = S_SCAN;
                  OP_DEL_ONE:              state_in = (!tgt_is_cur && tgt_live)
                                                      ? S_SCAN : S_DONE;
                  default:                 state_in = S_DONE;
               endcase
            end
         end
         S_STEP: state_in = S_DONE;
         S_SCAN: begin
            // closure repeats until a whole pass adds nothing
            if (pass_end && !(reach_mode && (changed_ff || changed_now))) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_rsp) state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // sequencer: datapath and table control
   // ---------------------------------------------------------------------------------
   always_comb begin
      cnt_in     = cnt_ff;
      cur_in     = cur_ff;
      valid_in   = valid_ff;
      op_in      = op_ff;
      bit_in     = bit_ff;
      tgt_in     = tgt_ff;
      reach_in   = reach_ff;
      changed_in = changed_ff;
      ref_in     = ref_ff;
      ucnt_in    = ucnt_ff;
      pvld_in    = 1'b0;
      pidx_in    = pidx_ff;
      pstat_in   = pstat_ff;
      pmask_in   = pmask_ff;
      pcount_in  = pcount_ff;
      wr0_en     = 1'b0;
      wr1_en     = 1'b0;
      wr_addr    = cur_ff;
      wr0_data   = tgt_idx;
      wr1_data   = tgt_idx;
      rd_addr    = cur_ff;

      unique case (state_ff)
         S_INIT: begin
            wr0_en   = 1'b1;
            wr1_en   = 1'b1;
            wr_addr  = cnt_ff[IDX_W-1:0];
            wr0_data = fill0[IDX_W-1:0];
            wr1_data = fill1[IDX_W-1:0];
            cnt_in   = cnt_ff + CNT_W'(1);
         end
         S_IDLE: begin
            // RAM is read at cur_ff here, so a step has its data next cycle
            if (accept) begin
               op_in      = req_op;
               bit_in     = req_bit;
               tgt_in     = tgt_idx;
               cnt_in     = '0;
               reach_in   = NUM_STATES'(1) << cur_ff;
               changed_in = 1'b0;
               ref_in     = 1'b0;
               ucnt_in    = '0;
               pstat_in   = ST_OK;
               pmask_in   = '0;
               pcount_in  = '0;
               case (req_op) inside
                  OP_STEP, OP_COLLECT, OP_DEL_UNR: ;
                  OP_EDIT: begin
                     if (tgt_live) begin
                        wr0_en = !req_bit;
                        wr1_en = req_bit;
                     end else begin
                        pstat_in = ST_REJECT;
                     end
                  end
                  OP_DEL_ONE: begin
                     if (tgt_is_cur)     pstat_in = ST_IS_CUR;
                     else if (!tgt_live) pstat_in = ST_REJECT;
                  end
                  default: pstat_in = ST_REJECT;
               endcase
            end
         end
         S_STEP: begin
            cur_in = bit_ff ? d1 : d0;
         end
         S_SCAN: begin
            rd_addr    = cnt_ff[IDX_W-1:0];
            pvld_in    = !pass_end;
            pidx_in    = cnt_ff[IDX_W-1:0];
            cnt_in     = cnt_ff + CNT_W'(1);
            reach_in   = reach_next;
            changed_in = changed_ff || changed_now;
            ref_in     = ref_ff || ref_now;
            ucnt_in    = ucnt_next;
            if (pass_end) begin
               if (reach_mode) begin
                  if (changed_ff || changed_now) begin
                     cnt_in     = '0;
                     changed_in = 1'b0;
                     ucnt_in    = '0;
                  end else begin
                     pmask_in  = unr_wide[MASK_W-1:0];
                     pcount_in = ucnt_next;
                     if (op_ff == OP_DEL_UNR) begin
                        if (ucnt_next == '0) pstat_in = ST_NONE;
                        else                 valid_in = valid_ff & reach_ff;
                     end
                  end
               end else begin
                  if (ref_ff || ref_now) pstat_in = ST_REF;
                  else                   valid_in[tgt_ff] = 1'b0;
               end
            end
         end
         S_DONE: ;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------------------
   always_comb begin
      rvld_in   = rvld_ff && !rsp_tready;
      rstate_in = rstate_ff;
      rmask_in  = rmask_ff;
      rcount_in = rcount_ff;
      rstat_in  = rstat_ff;
      if (load_rsp) begin
         rvld_in   = 1'b1;
         rstate_in = cur_cw[PS_W-1:0];
         rmask_in  = pmask_ff;
         rcount_in = pcount_ff;
         rstat_in  = pstat_ff;
      end
   end

   assign rsp_tvalid = rvld_ff;
   assign rsp_tdata  = {6'd0, rstat_ff, rcount_ff, rmask_ff, rstate_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= '0;
         cur_ff   <= '0;
         valid_ff <= '1;
         pvld_ff  <= 1'b0;
         rvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         cur_ff   <= cur_in;
         valid_ff <= valid_in;
         pvld_ff  <= pvld_in;
         rvld_ff  <= rvld_in;
      end
      op_ff      <= op_in;
      bit_ff     <= bit_in;
      tgt_ff     <= tgt_in;
      reach_ff   <= reach_in;
      changed_ff <= changed_in;
      ref_ff     <= ref_in;
      ucnt_ff    <= ucnt_in;
      pidx_ff    <= pidx_in;
      pstat_ff   <= pstat_in;
      pmask_ff   <= pmask_in;
      pcount_ff  <= pcount_in;
      rstate_ff  <= rstate_in;
      rmask_ff   <= rmask_in;
      rcount_ff  <= rcount_in;
      rstat_ff   <= rstat_in;
   end

endmodule

`default_nettype wire

// ===== rtl/efsm_check.sv =====
// Port-level checks for the editable state-machine block, bound to the top level.
// Depends on the top level's port list only.
`timescale 1ns / 1ps
`default_nettype none

module efsm_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   // a held result does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // table fill keeps commands out after reset
   a_fill_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("ready during table fill");

   // one command at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accepting an item");

   // nothing-to-delete comes with an empty report
   a_none_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[17:15] == 3'd3) |-> (rsp_tdata[14:11] == 4'd0)
                                                   && (rsp_tdata[10:3] == 8'd0))
      else $error("nothing-to-delete status with a nonempty report");

   // count covers at least the states shown in the mask
   a_count_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[14:11] >= 4'($countones(rsp_tdata[10:3])))
      else $error("count below mask population");

endmodule

bind editable_fsm_with_reachability_gc efsm_check u_efsm_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
